[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks used across the glyph layout block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked while reset is released.
`define TPGL_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("glyph layout assertion failed");
// Checked at every edge, reset included.
`define TPGL_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("glyph layout assertion failed");
`else
`define TPGL_ASSERT(lbl, clk, rstn, prop)
`define TPGL_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

[rtl/tpgl_pkg.sv]
// ----------------------------------------------------------------------------
// tpgl_pkg
// Shared types and constants of the text page glyph layout block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tpgl_pkg;

	localparam int TABLE_DEPTH_DEF = 256;
	localparam int COORD_BITS_DEF  = 16;

	typedef enum logic [1:0] {
		ACT_LOAD = 2'd0,
		ACT_PAGE = 2'd1,
		ACT_TEXT = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		PEND_NONE = 2'd0,
		PEND_LF   = 2'd1,
		PEND_FF   = 2'd2,
		PEND_7F   = 2'd3
	} pend_t;

	typedef enum logic [2:0] {
		REG_LEFT_START  = 3'd0,
		REG_TOP_START   = 3'd1,
		REG_LINE_HEIGHT = 3'd2,
		REG_ROWS        = 3'd3,
		REG_WRAP_LIMIT  = 3'd4,
		REG_WIDE_WIDTH  = 3'd5
	} reg_t;

	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_LF      = 8'h0A;
	localparam logic [7:0] CH_FF      = 8'hFF;
	localparam logic [7:0] CH_FE      = 8'hFE;
	localparam logic [7:0] CH_WIDE    = 8'h7F;
	localparam logic [7:0] IDX_LONEFF = 8'h3F;

	localparam logic [11:0] RST_LEFT_START  = 12'd0;
	localparam logic [11:0] RST_TOP_START   = 12'd0;
	localparam logic [7:0]  RST_LINE_HEIGHT = 8'd16;
	localparam logic [7:0]  RST_ROWS        = 8'd16;
	localparam logic [11:0] RST_WRAP_LIMIT  = 12'd240;
	localparam logic [7:0]  RST_WIDE_WIDTH  = 8'd16;

	typedef struct packed {
		logic [11:0] left_start;
		logic [11:0] top_start;
		logic [7:0]  line_height;
		logic [7:0]  rows_per_page;
		logic [11:0] wrap_limit;
		logic [7:0]  wide_char_width;
	} cfg_t;

	typedef struct packed {
		logic        kind;
		logic [15:0] glyph_code;
		logic [11:0] pen_x;
		logic [15:0] pen_y;
		logic        last;
	} result_t;

endpackage

[rtl/tpgl_wmem.sv]
// ----------------------------------------------------------------------------
// tpgl_wmem
// Glyph width memory with a registered read port and a copy of the lone
// 0xFF width entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpgl_wmem #(
	parameter int DEPTH = tpgl_pkg::TABLE_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [7:0]               wdata,
	output logic [7:0]               rdata,
	output logic [7:0]               lone_ff_width
);
	import tpgl_pkg::*;

	localparam int AW = $clog2(DEPTH);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;
	logic [7:0] lone_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	// The lone 0xFF width is needed in the same cycle as another table read.
	always_ff @(posedge clk) begin
		if (we && addr == AW'(IDX_LONEFF)) begin
			lone_q <= wdata;
		end
	end

	assign rdata         = rdata_q;
	assign lone_ff_width = lone_q;

endmodule

[rtl/tpgl_exec.sv]
// ----------------------------------------------------------------------------
// tpgl_exec
// Layout engine: pen, row and escape state, one result per cycle while the result queue has room.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tpgl_exec #(
	parameter int COORD_BITS = tpgl_pkg::COORD_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  tpgl_pkg::action_t  in_action,
	input  logic [7:0]         in_byte,
	output logic               in_ready,
	input  logic [7:0]         rd_width,
	input  logic [7:0]         lone_ff_width,
	input  tpgl_pkg::cfg_t     cfg,
	input  logic               room,
	output logic               push,
	output tpgl_pkg::result_t  res
);
	import tpgl_pkg::*;

	localparam int SUM_W = ((COORD_BITS > 12) ? COORD_BITS : 12) + 1;
	localparam logic [SUM_W-1:0] COORD_MAX = SUM_W'((1 << COORD_BITS) - 1);

	function automatic logic [COORD_BITS-1:0] sat(input logic [SUM_W-1:0] v);
		return (v > COORD_MAX) ? COORD_BITS'(COORD_MAX) : COORD_BITS'(v);
	endfunction

	logic                  valid_s1;
	action_t               action_s1;
	logic [7:0]            byte_s1;
	logic                  phase_q;
	logic [COORD_BITS-1:0] cx_q, cy_q;
	logic [7:0]            rows_q;
	pend_t                 pend_q;
	logic                  over_q;

	logic [COORD_BITS-1:0] cx_d, cy_d;
	logic [7:0]            rows_d;
	pend_t                 pend_d;
	logic                  over_d;

	pend_t                 p_eff;
	logic                  is_crlf, is_lf, is_ff, is_fe, is_7f;
	logic [15:0]           place_code;
	logic [7:0]            place_w;
	logic [SUM_W-1:0]      sum;
	logic                  wrap;
	logic [7:0]            rows_inc, rows_after, rows_after_inc;
	logic                  full, second_emits;
	logic [COORD_BITS-1:0] nl_x, nl_y, nl_adv, adv;
	logic                  path_byte, path_place, path_end;
	logic                  emit, go_p1, fire, done;

	// Second phase of a lone 0xFF: the following byte is taken as fresh text.
	assign p_eff   = phase_q ? PEND_NONE : pend_q;
	assign is_lf   = (byte_s1 == CH_LF);
	assign is_crlf = (byte_s1 == CH_CR) || is_lf;
	assign is_ff   = (byte_s1 == CH_FF);
	assign is_fe   = (byte_s1 == CH_FE);
	assign is_7f   = (byte_s1 == CH_WIDE);

	always_comb begin
		case (p_eff)
			PEND_FF: begin
				place_code = {8'h00, CH_FF};
				place_w    = lone_ff_width;
			end
			PEND_7F: begin
				place_code = {CH_WIDE, byte_s1};
				place_w    = cfg.wide_char_width;
			end
			default: begin
				place_code = {8'h00, byte_s1};
				place_w    = rd_width;
			end
		endcase
	end

	assign sum      = SUM_W'(cx_q) + SUM_W'(place_w);
	assign wrap     = sum > SUM_W'(cfg.wrap_limit);
	assign rows_inc = rows_q + 8'd1;
	assign full     = rows_inc >= cfg.rows_per_page;
	assign nl_x     = sat(SUM_W'(cfg.left_start));
	assign nl_y     = sat(SUM_W'(cy_q) + SUM_W'(cfg.line_height));
	assign nl_adv   = sat(SUM_W'(nl_x) + SUM_W'(place_w));
	assign adv      = sat(sum);

	// Tells whether the byte behind a lone 0xFF will itself give a result.
	assign rows_after     = wrap ? rows_inc : rows_q;
	assign rows_after_inc = rows_after + 8'd1;
	assign second_emits   = !(is_crlf || is_ff || is_7f) ||
	                        (is_crlf && rows_after_inc >= cfg.rows_per_page);

	always_comb begin
		cx_d       = cx_q;
		cy_d       = cy_q;
		rows_d     = rows_q;
		pend_d     = pend_q;
		over_d     = over_q;
		emit       = 1'b0;
		go_p1      = 1'b0;
		path_byte  = 1'b0;
		path_place = 1'b0;
		path_end   = 1'b0;
		res        = '0;
		res.last   = 1'b1;
		if (valid_s1 && action_s1 == ACT_PAGE) begin
			cx_d   = nl_x;
			cy_d   = sat(SUM_W'(cfg.top_start));
			rows_d = '0;
			pend_d = PEND_NONE;
			over_d = 1'b0;
			if (cfg.rows_per_page == 8'd0) begin
				path_end = 1'b1;
			end
		end else if (valid_s1 && action_s1 == ACT_TEXT && !over_q) begin
			pend_d = PEND_NONE;
			unique case (p_eff)
				PEND_LF: path_byte = !is_lf;
				PEND_FF: begin
					if (is_fe) begin
						path_end = 1'b1;
					end else begin
						path_place = 1'b1;
					end
				end
				PEND_7F: path_place = 1'b1;
				default: path_byte = 1'b1;
			endcase
			if (path_byte) begin
				if (is_crlf) begin
					rows_d = rows_inc;
					if (full) begin
						path_end = 1'b1;
					end else begin
						cx_d   = nl_x;
						cy_d   = nl_y;
						pend_d = PEND_LF;
					end
				end else if (is_ff) begin
					pend_d = PEND_FF;
				end else if (is_7f) begin
					pend_d = PEND_7F;
				end else begin
					path_place = 1'b1;
				end
			end
			if (path_place) begin
				res.glyph_code = place_code;
				if (wrap) begin
					rows_d = rows_inc;
					if (full) begin
						path_end = 1'b1;
					end else begin
						emit      = 1'b1;
						res.pen_x = 12'(nl_x);
						res.pen_y = 16'(nl_y);
						cx_d      = nl_adv;
						cy_d      = nl_y;
					end
				end else begin
					emit      = 1'b1;
					res.pen_x = 12'(cx_q);
					res.pen_y = 16'(cy_q);
					cx_d      = adv;
				end
				if (p_eff == PEND_FF && !path_end) begin
					go_p1    = 1'b1;
					res.last = !second_emits;
				end
			end
		end
		if (path_end) begin
			over_d = 1'b1;
			pend_d = PEND_NONE;
			emit   = 1'b1;
			res    = '0;
			res.kind = 1'b1;
			res.last = 1'b1;
		end
	end

	assign fire     = valid_s1 && room;
	assign done     = fire && !go_p1;
	assign push     = fire && emit;
	assign in_ready = !valid_s1 || done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_q  <= 1'b0;
			cx_q     <= '0;
			cy_q     <= '0;
			rows_q   <= '0;
			pend_q   <= PEND_NONE;
			over_q   <= 1'b1;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (fire) begin
				phase_q <= go_p1;
				cx_q    <= cx_d;
				cy_q    <= cy_d;
				rows_q  <= rows_d;
				pend_q  <= pend_d;
				over_q  <= over_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			action_s1 <= in_action;
			byte_s1   <= in_byte;
		end
	end

	// The second phase only exists for a text byte that follows a lone 0xFF.
	`TPGL_ASSERT(a_phase_has_item, clk, arst_n,
		phase_q |-> (valid_s1 && action_s1 == ACT_TEXT && !over_q && pend_q == PEND_NONE))
	// Nothing is pushed into a full result queue.
	`TPGL_ASSERT(a_push_needs_room, clk, arst_n, push |-> room)

endmodule

[rtl/tpgl_oq.sv]
// ----------------------------------------------------------------------------
// tpgl_oq
// Two-entry result queue that decouples the layout engine from the receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tpgl_oq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  tpgl_pkg::result_t push_data,
	output logic              room,
	output logic              out_valid,
	input  logic              out_ready,
	output tpgl_pkg::result_t out_data
);
	import tpgl_pkg::*;

	result_t    slot_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign out_valid = (count_q != 2'd0);
	assign room      = (count_q != 2'd2);
	assign pop       = out_valid && out_ready;
	assign out_data  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// The count is only meaningful once reset has been seen.
	`TPGL_ASSERT_ALWAYS(a_count_bound, clk, !arst_n || count_q != 2'd3)
	`TPGL_ASSERT(a_no_overflow, clk, arst_n, push |-> (count_q != 2'd2))

endmodule

[rtl/text_page_glyph_layout.sv]
// ----------------------------------------------------------------------------
// text_page_glyph_layout
// Turns a stream of text bytes into glyph placements and page-end markers.
// ----------------------------------------------------------------------------
// Input items arrive on the s_axis channel: tuser carries the action (load a
// width table entry, start a page, or a text byte), tdata the byte and width.
// Results leave on m_axis: tuser is the kind (glyph or page complete), tlast
// marks the final result of one input item. Registers are written through the
// cfg channel, which is always ready; write them only while the block is idle.
// An accepted item is registered into the engine stage, and its results pass
// through the result queue to m_axis. The block takes one item per cycle
// while the result queue has room; a text byte that follows a lone 0xFF is
// held for a second phase, because the engine places both glyphs in turn and
// produces one result per cycle; the width memory has one read port.
// Reset clears the pen, the row count and the escape state and leaves the
// block with the page closed: text is ignored until a page start. The width
// memory is not cleared; the user must load entries before they are read;
// the block does not enforce it. A receiver stall fills the two-entry result
// queue, which holds the engine and so drops s_axis_tready; nothing is lost.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_page_glyph_layout #(
	parameter int TABLE_DEPTH = tpgl_pkg::TABLE_DEPTH_DEF,
	parameter int COORD_BITS  = tpgl_pkg::COORD_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // text_byte[7:0], width_value[15:8]
	input  logic [1:0]  s_axis_tuser,   // action[1:0]
	// Result stream.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // glyph_code[15:0], pen_x[27:16],
	                                    // pen_y[43:28], zero fill[47:44]
	output logic        m_axis_tuser,   // kind
	output logic        m_axis_tlast,
	// Register writes.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [11:0] cfg_data
);
	import tpgl_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);

	cfg_t     cfg_q;
	action_t  in_action;
	logic     in_ready;
	logic     accept;
	logic [7:0] rd_width, lone_ff_width;
	logic     room, push;
	result_t  push_data, out_data;

	assign in_action     = action_t'(s_axis_tuser);
	assign s_axis_tready = in_ready;
	assign accept        = s_axis_tvalid && in_ready;

	// Register file. Writes are accepted every cycle; an unknown index is
	// accepted and dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.left_start      <= RST_LEFT_START;
			cfg_q.top_start       <= RST_TOP_START;
			cfg_q.line_height     <= RST_LINE_HEIGHT;
			cfg_q.rows_per_page   <= RST_ROWS;
			cfg_q.wrap_limit      <= RST_WRAP_LIMIT;
			cfg_q.wide_char_width <= RST_WIDE_WIDTH;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_t'(cfg_index))
				REG_LEFT_START:  cfg_q.left_start      <= cfg_data;
				REG_TOP_START:   cfg_q.top_start       <= cfg_data;
				REG_LINE_HEIGHT: cfg_q.line_height     <= cfg_data[7:0];
				REG_ROWS:        cfg_q.rows_per_page   <= cfg_data[7:0];
				REG_WRAP_LIMIT:  cfg_q.wrap_limit      <= cfg_data;
				REG_WIDE_WIDTH:  cfg_q.wide_char_width <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Table loads write at acceptance, so a text byte accepted in the next
	// cycle already reads the new width. Every accepted item launches a read;
	// its data waits in the memory's output register while the item is in
	// the engine, since no new item is accepted until the engine moves on.
	tpgl_wmem #(
		.DEPTH(TABLE_DEPTH)
	) u_wmem (
		.clk          (clk),
		.we           (accept && in_action == ACT_LOAD),
		.re           (accept),
		.addr         (AW'(s_axis_tdata[7:0])),
		.wdata        (s_axis_tdata[15:8]),
		.rdata        (rd_width),
		.lone_ff_width(lone_ff_width)
	);

	tpgl_exec #(
		.COORD_BITS(COORD_BITS)
	) u_exec (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_action    (in_action),
		.in_byte      (s_axis_tdata[7:0]),
		.in_ready     (in_ready),
		.rd_width     (rd_width),
		.lone_ff_width(lone_ff_width),
		.cfg          (cfg_q),
		.room         (room),
		.push         (push),
		.res          (push_data)
	);

	tpgl_oq u_oq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.room     (room),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_data (out_data)
	);

	assign m_axis_tdata = {4'b0000, out_data.pen_y, out_data.pen_x, out_data.glyph_code};
	assign m_axis_tuser = out_data.kind;
	assign m_axis_tlast = out_data.last;

endmodule

[verif/tpgl_layout_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpgl_layout_checker
// Watches the input, result and register channels of the glyph layout block.
// It keeps its own pen, row count, escape state, register copy and width
// memory, works out the placements that each input transaction should cause,
// and compares every result transaction with the oldest outstanding one.
// ----------------------------------------------------------------------------

module tpgl_layout_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,
	input  logic [1:0]  s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [47:0] m_axis_tdata,
	input  logic        m_axis_tuser,
	input  logic        m_axis_tlast,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [11:0] cfg_data,
	output int unsigned mismatches,
	output int unsigned glyphs_seen,
	output int unsigned pages_seen,
	output int unsigned pending_results,
	output logic        page_open
);
	import tpgl_pkg::*;

	localparam int unsigned PEN_MAX = (1 << COORD_BITS_DEF) - 1;

	cfg_t        regs;
	logic [7:0]  width_mem [0:TABLE_DEPTH_DEF-1];
	int unsigned pen_x_q;
	int unsigned pen_y_q;
	logic [7:0]  lines_used;
	pend_t       escape;
	logic        page_closed;
	result_t     item_res [0:1];
	int unsigned item_n;
	result_t     placements_q [$];

	function automatic int unsigned sat_pen(input int unsigned v);
		return (v > PEN_MAX) ? PEN_MAX : v;
	endfunction

	task automatic reset_layout();
		regs.left_start      = RST_LEFT_START;
		regs.top_start       = RST_TOP_START;
		regs.line_height     = RST_LINE_HEIGHT;
		regs.rows_per_page   = RST_ROWS;
		regs.wrap_limit      = RST_WRAP_LIMIT;
		regs.wide_char_width = RST_WIDE_WIDTH;
		pen_x_q     = 0;
		pen_y_q     = 0;
		lines_used  = '0;
		escape      = PEND_NONE;
		page_closed = 1'b1;
		placements_q.delete();
	endtask

	task automatic add_result(input logic kind, input logic [15:0] code,
			input int unsigned x, input int unsigned y);
		result_t r;
		r.kind       = kind;
		r.glyph_code = code;
		r.pen_x      = x[11:0];
		r.pen_y      = y[15:0];
		r.last       = 1'b0;
		if (item_n < 2) begin
			item_res[item_n] = r;
		end
		item_n++;
	endtask

	task automatic close_page();
		page_closed = 1'b1;
		escape      = PEND_NONE;
		add_result(1'b1, 16'h0000, 0, 0);
	endtask

	task automatic feed_line();
		pen_x_q = sat_pen(32'(regs.left_start));
		pen_y_q = sat_pen(pen_y_q + regs.line_height);
	endtask

	// A glyph that would end beyond the right edge moves down first; if that
	// uses up the last row the page closes instead of placing it.
	task automatic place_glyph(input logic [15:0] code, input int unsigned w);
		if (pen_x_q + w > regs.wrap_limit) begin
			lines_used = lines_used + 8'd1;
			if (lines_used >= regs.rows_per_page) begin
				close_page();
				return;
			end
			feed_line();
		end
		add_result(1'b0, code, pen_x_q, pen_y_q);
		pen_x_q = sat_pen(pen_x_q + w);
	endtask

	task automatic take_char(input logic [7:0] b);
		if (b == CH_CR || b == CH_LF) begin
			lines_used = lines_used + 8'd1;
			if (lines_used >= regs.rows_per_page) begin
				close_page();
				return;
			end
			feed_line();
			escape = PEND_LF;
		end else if (b == CH_FF) begin
			escape = PEND_FF;
		end else if (b == CH_WIDE) begin
			escape = PEND_7F;
		end else begin
			place_glyph({8'h00, b}, 32'(width_mem[b]));
		end
	endtask

	task automatic layout_item(input action_t act, input logic [7:0] b,
			input logic [7:0] w);
		pend_t prior;
		item_n = 0;
		case (act)
			ACT_LOAD: begin
				width_mem[b] = w;
			end
			ACT_PAGE: begin
				pen_x_q     = sat_pen(32'(regs.left_start));
				pen_y_q     = sat_pen(32'(regs.top_start));
				lines_used  = '0;
				escape      = PEND_NONE;
				page_closed = 1'b0;
				if (regs.rows_per_page == 8'd0) begin
					close_page();
				end
			end
			ACT_TEXT: begin
				if (!page_closed) begin
					prior  = escape;
					escape = PEND_NONE;
					case (prior)
						PEND_LF: begin
							if (b != CH_LF) begin
								take_char(b);
							end
						end
						PEND_FF: begin
							if (b == CH_FE) begin
								close_page();
							end else begin
								place_glyph({8'h00, CH_FF}, 32'(width_mem[IDX_LONEFF]));
								if (!page_closed) begin
									take_char(b);
								end
							end
						end
						PEND_7F: begin
							place_glyph({CH_WIDE, b}, 32'(regs.wide_char_width));
						end
						default: begin
							take_char(b);
						end
					endcase
				end
			end
			default: ;
		endcase
		if (item_n > 2) begin
			mismatches++;
			$display("%0t: layout predicted %0d results for one item", $time, item_n);
			item_n = 2;
		end
		if (item_n > 0) begin
			item_res[item_n - 1].last = 1'b1;
		end
		for (int k = 0; k < item_n; k++) begin
			placements_q.push_back(item_res[k]);
		end
	endtask

	task automatic write_register(input logic [2:0] idx, input logic [11:0] data);
		case (idx)
			REG_LEFT_START:  regs.left_start      = data;
			REG_TOP_START:   regs.top_start       = data;
			REG_LINE_HEIGHT: regs.line_height     = data[7:0];
			REG_ROWS:        regs.rows_per_page   = data[7:0];
			REG_WRAP_LIMIT:  regs.wrap_limit      = data;
			REG_WIDE_WIDTH:  regs.wide_char_width = data[7:0];
			default: ;
		endcase
	endtask

	function automatic void check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		result_t want;
		if (!arst_n) begin
			reset_layout();
			mismatches      = 0;
			glyphs_seen     = 0;
			pages_seen      = 0;
			pending_results <= 0;
			page_open       <= 1'b0;
		end else begin
			// Results are matched before new input is predicted, so a result can
			// never pair with an expectation raised at the same edge.
			if (m_axis_tvalid && m_axis_tready) begin
				if (placements_q.size() == 0) begin
					mismatches++;
					$display("%0t: result with nothing expected, kind %b data %h last %b",
						$time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
				end else begin
					want = placements_q.pop_front();
					check_field("kind", 16'(want.kind), 16'(m_axis_tuser));
					check_field("glyph_code", want.glyph_code, m_axis_tdata[15:0]);
					check_field("pen_x", 16'(want.pen_x), 16'(m_axis_tdata[27:16]));
					check_field("pen_y", want.pen_y, m_axis_tdata[43:28]);
					check_field("zero fill", 16'h0000, 16'(m_axis_tdata[47:44]));
					check_field("last", 16'(want.last), 16'(m_axis_tlast));
				end
				if (m_axis_tuser === 1'b1) begin
					pages_seen++;
				end else begin
					glyphs_seen++;
				end
			end
			if (cfg_valid && cfg_ready) begin
				write_register(cfg_index, cfg_data);
			end
			if (s_axis_tvalid && s_axis_tready) begin
				layout_item(action_t'(s_axis_tuser), s_axis_tdata[7:0], s_axis_tdata[15:8]);
			end
			pending_results <= placements_q.size();
			page_open       <= !page_closed;
		end
	end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the text page glyph layout block. A directed part
// walks through the line breaks, the escape pairs, the page ends and the
// register corner cases; a random part then streams text under many register
// settings, with idle gaps on both sides, a long receiver stall and a page
// that runs the pen into saturation. The checker beside the block does all
// prediction and comparison.
// ----------------------------------------------------------------------------

module tb_top;
	import tpgl_pkg::*;

	// Run sizing. The watchdog limit is far above the longest quiet stretch
	// of a correct run (long receiver hold plus a sender gap and a settle).
	localparam int unsigned ITEM_TARGET    = 950;
	localparam int unsigned SETTLE_CYCLES  = 8;
	localparam int unsigned END_CYCLES     = 10;
	localparam int unsigned RX_HOLD_CYCLES = 64;
	localparam int unsigned FLOOD_ITEMS    = 30;
	localparam int unsigned SAT_ITEMS      = 280;
	localparam int unsigned WATCHDOG_LIMIT = 2000;

	// Register index with no register behind it; a write there must change
	// nothing.
	localparam logic [2:0] REG_SPARE = 3'd7;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata  = '0;
	logic [1:0]  s_axis_tuser  = ACT_LOAD;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_valid     = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index     = '0;
	logic [11:0] cfg_data      = '0;

	int unsigned mismatches;
	int unsigned glyphs_seen;
	int unsigned pages_seen;
	int unsigned pending_results;
	logic        page_open;

	// Stimulus bookkeeping.
	bit          entry_loaded [0:255];
	int unsigned items_sent    = 0;
	int unsigned settings_used = 0;
	bit          no_gaps       = 1'b0;
	bit          rx_hold_req   = 1'b0;
	bit          rx_holding    = 1'b0;
	int unsigned quiet_cycles  = 0;

	text_page_glyph_layout dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	tpgl_layout_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_axis_tvalid   (s_axis_tvalid),
		.s_axis_tready   (s_axis_tready),
		.s_axis_tdata    (s_axis_tdata),
		.s_axis_tuser    (s_axis_tuser),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.m_axis_tuser    (m_axis_tuser),
		.m_axis_tlast    (m_axis_tlast),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.mismatches      (mismatches),
		.glyphs_seen     (glyphs_seen),
		.pages_seen      (pages_seen),
		.pending_results (pending_results),
		.page_open       (page_open)
	);

	always #10 clk = ~clk;

	// Sender idle gaps: mostly none or short, now and then a long one. Inside a
	// no-gap stretch the sender offers a new item at every edge.
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (no_gaps) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(6, 30);
	endfunction

	// Widths stay small most of the time so that a line holds several glyphs;
	// the wide ones force wraps.
	function automatic logic [7:0] rand_width();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 5) begin
			return 8'd0;
		end
		if (r < 85) begin
			return 8'($urandom_range(1, 24));
		end
		return 8'($urandom_range(25, 255));
	endfunction

	// Called at a rising edge; returns at the edge where the transaction was
	// accepted, with tvalid still high so that the next item can follow at once.
	task automatic send_item(input action_t act, input logic [7:0] b, input logic [7:0] w);
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {w, b};
		s_axis_tuser  <= act;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		items_sent++;
	endtask

	task automatic load_width(input logic [7:0] idx, input logic [7:0] w);
		send_item(ACT_LOAD, idx, w);
		entry_loaded[idx] = 1'b1;
	endtask

	// Every text byte is preceded, once, by a load of its own width entry and
	// of the lone 0xFF entry, so no unwritten entry is ever read.
	task automatic put_text(input logic [7:0] b);
		logic [7:0] junk;
		if (!entry_loaded[b]) begin
			load_width(b, rand_width());
		end
		if (!entry_loaded[IDX_LONEFF]) begin
			load_width(IDX_LONEFF, rand_width());
		end
		junk = 8'($urandom_range(0, 255));
		send_item(ACT_TEXT, b, junk);
	endtask

	task automatic start_page();
		logic [7:0] b;
		logic [7:0] w;
		b = 8'($urandom_range(0, 255));
		w = 8'($urandom_range(0, 255));
		send_item(ACT_PAGE, b, w);
	endtask

	// Lower tvalid, wait for every expected result and then for the pipeline
	// to settle, since loads and swallowed bytes leave no result to wait for.
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [11:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Eight-bit registers get random upper data bits, which must be dropped.
	task automatic write_byte_reg(input logic [2:0] idx, input logic [7:0] val);
		logic [3:0] junk;
		junk = 4'($urandom_range(0, 15));
		write_reg(idx, {junk, val});
	endtask

	task automatic apply_random_settings();
		int unsigned left;
		int unsigned edge_x;
		logic [7:0]  v;
		left = ($urandom_range(0, 9) == 0) ? 0 :
			($urandom_range(0, 19) == 0) ? 4095 : $urandom_range(0, 300);
		edge_x = left + $urandom_range(40, 600);
		if (edge_x > 4095) begin
			edge_x = 4095;
		end
		if ($urandom_range(0, 9) == 0) begin
			edge_x = 0;
		end
		if ($urandom_range(0, 3) != 0) begin
			write_reg(REG_LEFT_START, 12'(left));
		end
		if ($urandom_range(0, 3) != 0) begin
			write_reg(REG_TOP_START, ($urandom_range(0, 9) == 0) ? 12'd4095 :
				12'($urandom_range(0, 1000)));
		end
		if ($urandom_range(0, 3) != 0) begin
			v = ($urandom_range(0, 9) == 0) ? 8'd1 :
				($urandom_range(0, 9) == 0) ? 8'd255 : 8'($urandom_range(1, 40));
			write_byte_reg(REG_LINE_HEIGHT, v);
		end
		if ($urandom_range(0, 3) != 0) begin
			v = ($urandom_range(0, 9) == 0) ? 8'd1 :
				($urandom_range(0, 9) == 0) ? 8'd255 : 8'($urandom_range(2, 12));
			write_byte_reg(REG_ROWS, v);
		end
		if ($urandom_range(0, 3) != 0) begin
			write_reg(REG_WRAP_LIMIT, 12'(edge_x));
		end
		if ($urandom_range(0, 3) != 0) begin
			v = ($urandom_range(0, 9) == 0) ? 8'd0 :
				($urandom_range(0, 9) == 0) ? 8'd255 : 8'($urandom_range(4, 40));
			write_byte_reg(REG_WIDE_WIDTH, v);
		end
		settings_used++;
	endtask

	// One token of text: mostly plain glyphs, with line breaks, the escape
	// pairs, page ends, page starts, width reloads and a little noise mixed in.
	// A closed page is usually reopened first so that the stream stays live.
	task automatic send_token();
		int unsigned r;
		logic [7:0]  b;
		logic [7:0]  w;
		r = $urandom_range(0, 99);
		b = 8'($urandom_range(0, 255));
		w = 8'($urandom_range(0, 255));
		if (!page_open && $urandom_range(0, 3) != 0) begin
			start_page();
		end else if (r < 55) begin
			put_text(b);
		end else if (r < 63) begin
			put_text(CH_CR);
		end else if (r < 68) begin
			put_text(CH_LF);
		end else if (r < 73) begin
			put_text(CH_CR);
			put_text(CH_LF);
		end else if (r < 79) begin
			put_text(CH_WIDE);
			put_text(b);
		end else if (r < 85) begin
			put_text(CH_FF);
			put_text(b);
		end else if (r < 88) begin
			put_text(CH_FF);
			put_text(CH_FE);
		end else if (r < 91) begin
			start_page();
		end else if (r < 96) begin
			load_width(b, rand_width());
		end else if (r < 98) begin
			send_item(ACT_NONE, b, w);
		end else begin
			load_width(b, w);
		end
	endtask

	// Receiver: random ready patterns, a long ready run now and then, and a
	// long hold-off on request, counted here in cycles.
	initial begin : receiver
		int unsigned r;
		int unsigned run;
		@(posedge arst_n);
		forever begin
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				rx_holding  = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
				rx_holding = 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 55) begin
					m_axis_tready <= 1'b1;
					run = $urandom_range(1, 24);
				end else if (r < 60) begin
					m_axis_tready <= 1'b1;
					run = 100;
				end else if (r < 92) begin
					m_axis_tready <= 1'b0;
					run = $urandom_range(1, 3);
				end else begin
					m_axis_tready <= 1'b0;
					run = $urandom_range(8, 40);
				end
				repeat (run) @(posedge clk);
			end
		end
	end

	// Watchdog: any accepted transaction on any channel counts as progress.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(cfg_valid && cfg_ready)) begin
				quiet_cycles = 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end else begin
				quiet_cycles++;
			end
		end
	end

	initial begin : stimulus
		int unsigned phase;
		int unsigned n;
		int unsigned i;
		logic [7:0]  b;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---------------- Directed part ----------------
		// A narrow page of three rows so that wraps and page ends come quickly.
		write_reg(REG_LEFT_START, 12'd4);
		write_reg(REG_TOP_START, 12'd8);
		write_byte_reg(REG_LINE_HEIGHT, 8'd12);
		write_byte_reg(REG_ROWS, 8'd3);
		write_reg(REG_WRAP_LIMIT, 12'd100);
		write_byte_reg(REG_WIDE_WIDTH, 8'd20);
		write_reg(REG_SPARE, 12'hFFF);
		settings_used++;

		load_width(8'h41, 8'd30);
		load_width(8'h00, 8'd0);
		load_width(IDX_LONEFF, 8'd10);
		load_width(8'hC3, 8'd255);

		// Text before any page start and the unused action are both ignored.
		put_text(8'h41);
		send_item(ACT_NONE, 8'hFF, 8'hFF);

		start_page();
		put_text(8'h00);          // zero width glyph at the left edge
		put_text(8'h41);
		put_text(CH_CR);          // new line
		put_text(CH_LF);          // swallowed after CR
		put_text(CH_LF);          // a second LF is a line of its own
		put_text(8'h41);
		put_text(CH_WIDE);        // two-byte code, the CR is its low byte
		put_text(CH_CR);
		put_text(CH_FF);          // lone 0xFF, then a glyph
		put_text(8'h41);
		put_text(CH_FF);          // page end pair
		put_text(CH_FE);
		put_text(8'h41);          // ignored after the page end

		// Full-width glyphs wrap on every placement until the rows run out.
		start_page();
		put_text(8'hC3);
		put_text(8'hC3);
		put_text(8'hC3);

		// With no rows, a page start completes the page at once.
		drain_results();
		write_byte_reg(REG_ROWS, 8'd0);
		start_page();
		put_text(8'h41);

		// A lone 0xFF that wraps past the only row ends the page and the byte
		// after it is dropped.
		drain_results();
		write_byte_reg(REG_ROWS, 8'd1);
		load_width(IDX_LONEFF, 8'd255);
		start_page();
		put_text(CH_FF);
		put_text(8'h41);

		// A lone 0xFF placed on a wrapped line, then a CR that ends the page.
		drain_results();
		write_byte_reg(REG_ROWS, 8'd2);
		settings_used++;
		start_page();
		put_text(CH_FF);
		put_text(CH_CR);

		// ---------------- Deep page: pen_y saturation ----------------
		// Bottom-most start, tallest lines and all rows: the pen saturates in y
		// after about 240 lines, and the 255th line closes the page.
		drain_results();
		write_reg(REG_LEFT_START, 12'd0);
		write_reg(REG_TOP_START, 12'd4095);
		write_byte_reg(REG_LINE_HEIGHT, 8'd255);
		write_byte_reg(REG_ROWS, 8'd255);
		write_reg(REG_WRAP_LIMIT, 12'd4095);
		write_byte_reg(REG_WIDE_WIDTH, 8'd255);
		settings_used++;
		start_page();
		for (i = 0; i < SAT_ITEMS; i++) begin
			if (i % 12 == 11) begin
				b = 8'($urandom_range(0, 255));
				put_text(b);
			end else begin
				put_text(CH_CR);
			end
		end

		// ---------------- Random part ----------------
		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			drain_results();
			apply_random_settings();
			if (phase == 1) begin
				// Long receiver hold while the sender keeps offering back to
				// back: the result queue fills and the input stalls.
				rx_hold_req = 1'b1;
				while (!rx_holding) @(posedge clk);
				no_gaps = 1'b1;
				start_page();
				for (i = 0; i < FLOOD_ITEMS; i++) begin
					b = 8'($urandom_range(0, 255));
					put_text(b);
				end
			end else begin
				no_gaps = ($urandom_range(0, 3) == 0);
				if ($urandom_range(0, 2) != 0) begin
					start_page();
				end
				n = $urandom_range(20, 60);
				repeat (n) send_token();
			end
			no_gaps = 1'b0;
			phase++;
		end

		// ---------------- Wind-down and verdict ----------------
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0) @(posedge clk);
		repeat (END_CYCLES) @(posedge clk);

		$display("Covered %0d input transactions under %0d register settings, a saturated page",
			items_sent, settings_used);
		$display("and a long output stall; checked %0d glyph and %0d page-complete results.",
			glyphs_seen, pages_seen);
		if (mismatches == 0 && pending_results == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
